[sv/dgr_pkg.sv]
// Shared types and constants of the grid ray caster.
`timescale 1ns / 1ps
`default_nettype none
package dgr_pkg;

    localparam int DIV_W   = 48;
    localparam int CNT_W   = 6;
    localparam int CAM_W   = 28;
    localparam int PROD_W  = 46;
    localparam int RAY_W   = 31;
    localparam int DELTA_W = 41;
    localparam int SIDE_W  = 48;
    localparam int COORD_W = 10;
    localparam int FRAC_W  = 17;

    typedef enum logic [2:0] {
        CFG_POS_X,
        CFG_POS_Y,
        CFG_DIR_X,
        CFG_DIR_Y,
        CFG_PLANE_X,
        CFG_PLANE_Y,
        CFG_EXTENT_X,
        CFG_EXTENT_Y
    } cfg_index_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[sv/dgr_map_ram.sv]
// Wall map storage: one bit per cell, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dgr_map_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire          aclk,
    input  wire          wr_en,
    input  wire [AW-1:0] wr_addr,
    input  wire          wr_data,
    input  wire [AW-1:0] rd_addr,
    output logic         rd_data
);

    logic mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[sv/dgr_divider.sv]
// Restoring unsigned divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dgr_divider (
    input  wire               aclk,
    input  wire               aresetn,
    input  dgr_pkg::div_req_t req,
    output dgr_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [dgr_pkg::CNT_W-1:0]     cnt_reg;
    logic [dgr_pkg::DIV_W-1:0]     rem_reg;
    logic [dgr_pkg::DIV_W-1:0]     quo_reg;
    logic [dgr_pkg::DIV_W-1:0]     dvs_reg;
    logic [dgr_pkg::DIV_W:0]       trial;
    logic                          ge;
    logic [dgr_pkg::DIV_W-1:0]     rem_next;
    logic [dgr_pkg::DIV_W:0]       diff;

    assign trial    = {rem_reg, quo_reg[dgr_pkg::DIV_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[dgr_pkg::DIV_W-1:0] : trial[dgr_pkg::DIV_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[dgr_pkg::DIV_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == dgr_pkg::CNT_W'(dgr_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

[sv/dda_grid_raycaster.sv]
// Grid ray caster: a wall map in block memory walked cell by cell with DDA.
// Input channel (s_*): operation 0 writes one map cell and produces no result;
// operation 1 casts the ray of a screen column and produces one result on m_*.
// The configuration channel (cfg_*) is always ready and writes the camera
// position, direction, plane and map extent; the user is to write it while
// the block is idle, as the block itself does not enforce this. A cast works
// out in turn the camera value (a constant reciprocal multiply), the ray
// multiplies, the two reciprocals in the shared one-bit-per-cycle divider,
// the start distances, the grid steps, the stripe height in the same divider
// and the registered result; every grid step reads the map memory, whose read
// data is registered. A zero ray component or a zero distance skips its division.
// One cast is in flight at a time; s_ready is high only while no cast is at
// work. The result sits in an output register; a stall on m_ready holds it and
// a finished cast waits until the register frees, while a new item may still be
// taken once the result is registered. Reset clears the control state and
// returns the configuration to its defaults; the map is not cleared and a cell
// must be written before a ray reads it.
`timescale 1ns / 1ps
`default_nettype none
module dda_grid_raycaster #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAP_DIM       = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [21:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_operation,
    input  wire  [9:0]  s_column,
    input  wire  [5:0]  s_cell_x,
    input  wire  [5:0]  s_cell_y,
    input  wire         s_cell_solid,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [9:0]  m_result_column,
    output logic        m_wall_side,
    output logic [23:0] m_perp_distance,
    output logic [15:0] m_line_height,
    output logic [8:0]  m_draw_start,
    output logic [8:0]  m_draw_end
);

    localparam int DEPTH  = MAP_DIM * MAP_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int HALF   = SCREEN_HEIGHT / 2;
    localparam int CAM_QK = 131072 / SCREEN_WIDTH;
    localparam int CAM_RK = 131072 % SCREEN_WIDTH;
    localparam int CAM_SH = 34;
    localparam int CAM_PW = 56;
    localparam logic [33:0] CAM_RECIP =
        34'(((64'd1 << CAM_SH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    typedef enum logic [3:0] {
        ST_IDLE, ST_CAM, ST_MUL_X, ST_MUL_Y, ST_RAY_Y, ST_DX_START,
        ST_DX_WAIT, ST_DY_START, ST_DY_WAIT, ST_INIT_X, ST_INIT_Y, ST_STEP,
        ST_CHECK, ST_LINE_START, ST_LINE_WAIT, ST_FINISH
    } state_t;

    state_t state_reg;

    logic        [21:0] pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic        [6:0]  ext_x_reg, ext_y_reg;

    logic        [9:0]                      column_reg;
    logic        [21:0]                     cam_lo_reg;
    logic        [26:0]                     cam_hi_reg;
    logic signed [dgr_pkg::CAM_W-1:0]       cam_reg;
    logic signed [dgr_pkg::PROD_W-1:0]      prod_reg;
    logic signed [dgr_pkg::RAY_W-1:0]       rx_reg, ry_reg;
    logic        [dgr_pkg::DELTA_W-1:0]     dx_reg, dy_reg;
    logic        [dgr_pkg::SIDE_W-1:0]      sx_reg, sy_reg, perp_reg;
    logic signed [dgr_pkg::COORD_W-1:0]     mx_reg, my_reg;
    logic                                   side_reg;
    logic        [15:0]                     line_reg;
    logic                                   m_valid_reg;

    logic        [dgr_pkg::SIDE_W-1:0]      sx_next, sy_next;
    logic signed [dgr_pkg::COORD_W-1:0]     mx_next, my_next;
    logic                                   side_next;

    dgr_pkg::div_req_t div_req;
    dgr_pkg::div_rsp_t div_rsp;

    logic            s_fire;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [16:0]     waddr_full, raddr_full;
    logic            ram_rd;
    logic [8:0]      ex, ey;
    logic            oob;
    logic [CAM_PW-1:0] cam_prod;
    logic [dgr_pkg::RAY_W-1:0] rx_mag, ry_mag;
    logic [dgr_pkg::FRAC_W-1:0] frac_x, frac_y;
    logic [16:0]     half_line, draw_s, draw_e, sum_e;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= 18'sd65536;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 18'sd43254;
            ext_x_reg   <= 7'd64;
            ext_y_reg   <= 7'd64;
        end else if (cfg_valid && cfg_ready) begin
            unique case (dgr_pkg::cfg_index_t'(cfg_index))
                dgr_pkg::CFG_POS_X:    pos_x_reg   <= cfg_data;
                dgr_pkg::CFG_POS_Y:    pos_y_reg   <= cfg_data;
                dgr_pkg::CFG_DIR_X:    dir_x_reg   <= cfg_data[17:0];
                dgr_pkg::CFG_DIR_Y:    dir_y_reg   <= cfg_data[17:0];
                dgr_pkg::CFG_PLANE_X:  plane_x_reg <= cfg_data[17:0];
                dgr_pkg::CFG_PLANE_Y:  plane_y_reg <= cfg_data[17:0];
                dgr_pkg::CFG_EXTENT_X: ext_x_reg   <= cfg_data[6:0];
                dgr_pkg::CFG_EXTENT_Y: ext_y_reg   <= cfg_data[6:0];
            endcase
        end
    end

    assign waddr_full = 17'(s_cell_y) * 17'(MAP_DIM) + 17'(s_cell_x);
    assign ram_waddr  = waddr_full[AW-1:0];
    assign ram_we     = s_fire && !s_operation
                        && (9'(s_cell_x) < 9'(MAP_DIM)) && (9'(s_cell_y) < 9'(MAP_DIM));

    always_comb begin
        if (sx_reg < sy_reg) begin
            sx_next   = sx_reg + dgr_pkg::SIDE_W'(dx_reg);
            sy_next   = sy_reg;
            mx_next   = rx_reg[dgr_pkg::RAY_W-1] ? mx_reg - dgr_pkg::COORD_W'(1)
                                                 : mx_reg + dgr_pkg::COORD_W'(1);
            my_next   = my_reg;
            side_next = 1'b0;
        end else begin
            sx_next   = sx_reg;
            sy_next   = sy_reg + dgr_pkg::SIDE_W'(dy_reg);
            mx_next   = mx_reg;
            my_next   = ry_reg[dgr_pkg::RAY_W-1] ? my_reg - dgr_pkg::COORD_W'(1)
                                                 : my_reg + dgr_pkg::COORD_W'(1);
            side_next = 1'b1;
        end
    end

    assign raddr_full = 17'(my_next[8:0]) * 17'(MAP_DIM) + 17'(mx_next[8:0]);
    assign ram_raddr  = raddr_full[AW-1:0];

    dgr_map_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_map (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(s_cell_solid),
        .rd_addr(ram_raddr),
        .rd_data(ram_rd)
    );

    assign ex  = ({2'b0, ext_x_reg} > 9'(MAP_DIM)) ? 9'(MAP_DIM) : {2'b0, ext_x_reg};
    assign ey  = ({2'b0, ext_y_reg} > 9'(MAP_DIM)) ? 9'(MAP_DIM) : {2'b0, ext_y_reg};
    assign oob = (mx_reg < 0) || (mx_reg >= $signed({1'b0, ex}))
                 || (my_reg < 0) || (my_reg >= $signed({1'b0, ey}));

    assign cam_prod = {34'b0, cam_lo_reg} * {22'b0, CAM_RECIP};

    assign rx_mag = rx_reg[dgr_pkg::RAY_W-1] ? -rx_reg : rx_reg;
    assign ry_mag = ry_reg[dgr_pkg::RAY_W-1] ? -ry_reg : ry_reg;
    assign frac_x = rx_reg[dgr_pkg::RAY_W-1] ? {1'b0, pos_x_reg[15:0]}
                                             : 17'h10000 - {1'b0, pos_x_reg[15:0]};
    assign frac_y = ry_reg[dgr_pkg::RAY_W-1] ? {1'b0, pos_y_reg[15:0]}
                                             : 17'h10000 - {1'b0, pos_y_reg[15:0]};

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            ST_DX_START: begin
                div_req.start    = (rx_reg != 0);
                div_req.dividend = dgr_pkg::DIV_W'(64'd1 << 32);
                div_req.divisor  = dgr_pkg::DIV_W'(rx_mag);
            end
            ST_DY_START: begin
                div_req.start    = (ry_reg != 0);
                div_req.dividend = dgr_pkg::DIV_W'(64'd1 << 32);
                div_req.divisor  = dgr_pkg::DIV_W'(ry_mag);
            end
            ST_LINE_START: begin
                div_req.start    = (perp_reg != 0);
                div_req.dividend = dgr_pkg::DIV_W'(64'(SCREEN_HEIGHT) << 16);
                div_req.divisor  = perp_reg;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    dgr_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    assign half_line = {1'b0, line_reg[15:1]};
    assign draw_s    = (half_line >= 17'(HALF)) ? '0 : 17'(HALF) - half_line;
    assign sum_e     = half_line + 17'(HALF);
    assign draw_e    = (sum_e >= 17'(SCREEN_HEIGHT)) ? 17'(SCREEN_HEIGHT - 1) : sum_e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_operation) begin
                        column_reg <= s_column;
                        cam_lo_reg <= 22'(s_column) * 22'(CAM_RK);
                        cam_hi_reg <= 27'(s_column) * 27'(CAM_QK);
                        state_reg  <= ST_CAM;
                    end
                end
                ST_CAM: begin
                    cam_reg   <= dgr_pkg::CAM_W'(cam_hi_reg)
                                 + dgr_pkg::CAM_W'(cam_prod[CAM_PW-1:CAM_SH])
                                 - dgr_pkg::CAM_W'(65536);
                    state_reg <= ST_MUL_X;
                end
                ST_MUL_X: begin
                    prod_reg  <= plane_x_reg * cam_reg;
                    state_reg <= ST_MUL_Y;
                end
                ST_MUL_Y: begin
                    rx_reg    <= dgr_pkg::RAY_W'(dir_x_reg)
                                 + dgr_pkg::RAY_W'(prod_reg >>> 16);
                    prod_reg  <= plane_y_reg * cam_reg;
                    state_reg <= ST_RAY_Y;
                end
                ST_RAY_Y: begin
                    ry_reg    <= dgr_pkg::RAY_W'(dir_y_reg)
                                 + dgr_pkg::RAY_W'(prod_reg >>> 16);
                    state_reg <= ST_DX_START;
                end
                ST_DX_START: begin
                    if (rx_reg == 0) begin
                        dx_reg    <= dgr_pkg::DELTA_W'(64'd1 << 40);
                        state_reg <= ST_DY_START;
                    end else begin
                        state_reg <= ST_DX_WAIT;
                    end
                end
                ST_DX_WAIT: begin
                    if (div_rsp.done) begin
                        dx_reg    <= div_rsp.quotient[dgr_pkg::DELTA_W-1:0];
                        state_reg <= ST_DY_START;
                    end
                end
                ST_DY_START: begin
                    if (ry_reg == 0) begin
                        dy_reg    <= dgr_pkg::DELTA_W'(64'd1 << 40);
                        state_reg <= ST_INIT_X;
                    end else begin
                        state_reg <= ST_DY_WAIT;
                    end
                end
                ST_DY_WAIT: begin
                    if (div_rsp.done) begin
                        dy_reg    <= div_rsp.quotient[dgr_pkg::DELTA_W-1:0];
                        state_reg <= ST_INIT_X;
                    end
                end
                ST_INIT_X: begin
                    sx_reg    <= dgr_pkg::SIDE_W'((58'(frac_x) * 58'(dx_reg)) >> 16);
                    mx_reg    <= dgr_pkg::COORD_W'(pos_x_reg[21:16]);
                    state_reg <= ST_INIT_Y;
                end
                ST_INIT_Y: begin
                    sy_reg    <= dgr_pkg::SIDE_W'((58'(frac_y) * 58'(dy_reg)) >> 16);
                    my_reg    <= dgr_pkg::COORD_W'(pos_y_reg[21:16]);
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    sx_reg    <= sx_next;
                    sy_reg    <= sy_next;
                    mx_reg    <= mx_next;
                    my_reg    <= my_next;
                    side_reg  <= side_next;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (oob || ram_rd) begin
                        perp_reg  <= side_reg ? sy_reg - dgr_pkg::SIDE_W'(dy_reg)
                                              : sx_reg - dgr_pkg::SIDE_W'(dx_reg);
                        state_reg <= ST_LINE_START;
                    end else begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_LINE_START: begin
                    if (perp_reg == 0) begin
                        line_reg  <= 16'hFFFF;
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_LINE_WAIT;
                    end
                end
                ST_LINE_WAIT: begin
                    if (div_rsp.done) begin
                        line_reg  <= (div_rsp.quotient > dgr_pkg::DIV_W'(65535))
                                     ? 16'hFFFF : div_rsp.quotient[15:0];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_result_column <= column_reg;
                        m_wall_side     <= side_reg;
                        m_perp_distance <= (perp_reg > dgr_pkg::SIDE_W'(24'hFFFFFF))
                                           ? 24'hFFFFFF : perp_reg[23:0];
                        m_line_height   <= line_reg;
                        m_draw_start    <= draw_s[8:0];
                        m_draw_end      <= draw_e[8:0];
                        state_reg       <= ST_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ram_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == ST_IDLE)
        else $error("map write outside idle");

    a_check_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> $past(state_reg) == ST_STEP)
        else $error("map check without a preceding step");

    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DX_WAIT || state_reg == ST_DY_WAIT
                          || state_reg == ST_LINE_WAIT))
        else $error("divider result with no consumer");
`endif

endmodule
`default_nettype wire
